/* design/spc_pkg.sv */
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants for the stepper axis position controller.
// ----------------------------------------------------------------------------
package spc_pkg;

	// Width of the saturating millisecond counter.
	localparam int TIME_BITS = 16;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_OPENING      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_OPENING      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOME_POSITION    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOMING_DIRECTION = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD_MS   = 3'd4;
	localparam int CFG_DATA_W = 8;

	// Reset values of the configuration registers.
	localparam logic [6:0] MIN_OPENING_RST    = 7'd0;
	localparam logic [6:0] MAX_OPENING_RST    = 7'd100;
	localparam logic [6:0] HOME_POSITION_RST  = 7'd0;
	localparam logic [7:0] STEP_PERIOD_MS_RST = 8'd10;

	// Behavior constants.
	localparam logic [7:0] RECOVER_MARGIN  = 8'd6;
	localparam logic [6:0] HOME_SPLIT      = 7'd50;
	localparam logic [7:0] HOMING_START    = 8'd100;
	localparam int         MS_PER_TENTH    = 100;

	// Item kinds.
	localparam logic FUNC_COMMAND = 1'b0;
	localparam logic FUNC_TICK    = 1'b1;

	typedef struct packed {
		logic [6:0] min_opening;
		logic [6:0] max_opening;
		logic [6:0] home_position;
		logic       homing_direction;
		logic [7:0] step_period_ms;
	} spc_cfg_t;

	typedef struct packed {
		logic       func;
		logic       home_request;
		logic [7:0] target_position;
		logic [7:0] step_time_tenths;
		logic       limit_active;
	} spc_item_t;

	typedef struct packed {
		logic [7:0]           position;
		logic [7:0]           setpoint;
		logic [7:0]           step_time;
		logic                 homing;
		logic                 recovering;
		logic [7:0]           recover_target;
		logic                 mid_step;
		logic [TIME_BITS-1:0] ms_since_move;
		logic                 all_in_place;
		logic                 pin_step;
		logic                 pin_dir;
		logic                 pin_enable;
		logic                 pin_low;
	} spc_state_t;

	typedef struct packed {
		logic       step_pin;
		logic       dir_pin;
		logic       enable_on;
		logic       low_current;
		logic [7:0] position_now;
		logic       at_setpoint;
		logic       in_place_event;
	} spc_result_t;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

/* design/spc_next_state.sv */
// ----------------------------------------------------------------------------
// spc_next_state
// Next-state and result logic for one command or tick word.
// ----------------------------------------------------------------------------
module spc_next_state (
	input  spc_pkg::spc_cfg_t    cfg,
	input  spc_pkg::spc_item_t   item,
	input  spc_pkg::spc_state_t  cur,
	output spc_pkg::spc_state_t  nxt,
	output spc_pkg::spc_result_t res
);
	import spc_pkg::*;

	spc_state_t           s;
	logic                 evt;
	logic [7:0]           tgt;
	logic [7:0]           home8;
	logic [TIME_BITS-1:0] step_thresh;
	logic [TIME_BITS-1:0] period_ms;

	// One half-step pin toggle.
	function automatic spc_state_t half_step(input spc_state_t st);
		spc_state_t r;
		r               = st;
		r.pin_step      = st.mid_step;
		r.mid_step      = ~st.mid_step;
		r.ms_since_move = '0;
		return r;
	endfunction

	assign home8       = {1'b0, cfg.home_position};
	assign step_thresh = TIME_BITS'(cur.step_time) * TIME_BITS'(MS_PER_TENTH);
	assign period_ms   = TIME_BITS'(cfg.step_period_ms);

	always_comb begin
		s   = cur;
		evt = 1'b0;
		tgt = item.target_position;
		if (item.func == FUNC_COMMAND) begin
			if (item.home_request) begin
				s.homing   = 1'b1;
				s.setpoint = home8;
				s.position = HOMING_START;
			end else begin
				if (tgt < {1'b0, cfg.min_opening}) begin
					tgt = {1'b0, cfg.min_opening};
				end else if (tgt > {1'b0, cfg.max_opening}) begin
					tgt = {1'b0, cfg.max_opening};
				end
				s.setpoint  = tgt;
				s.step_time = item.step_time_tenths;
			end
		end else begin
			if (s.ms_since_move != '1) begin
				s.ms_since_move = s.ms_since_move + TIME_BITS'(1);
			end
			// Switch hit far from home: the position was lost, walk it back.
			if (!s.homing && !s.recovering && item.limit_active &&
			    abs_diff(s.position, home8) > RECOVER_MARGIN &&
			    abs_diff(s.setpoint, home8) > RECOVER_MARGIN) begin
				s.recovering     = 1'b1;
				s.recover_target = s.position;
				s.position       = home8;
			end
			if (s.position == s.setpoint) begin
				if (!s.all_in_place) begin
					s.all_in_place = 1'b1;
					evt            = 1'b1;
				end
			end else begin
				s.all_in_place = 1'b0;
				if (s.ms_since_move > period_ms) begin
					if (s.mid_step) begin
						s = half_step(s);
					end else if (s.homing) begin
						if (!item.limit_active) begin
							s.pin_enable = 1'b1;
							s.pin_low    = 1'b1;
							s.pin_dir    = cfg.home_position > HOME_SPLIT;
							s            = half_step(s);
						end else begin
							s.pin_enable = 1'b0;
							s.position   = home8;
							s.homing     = 1'b0;
						end
					end else if (s.recovering) begin
						s.pin_enable = 1'b1;
						s.pin_low    = 1'b0;
						if (s.recover_target > home8) begin
							s.pin_dir  = 1'b1;
							s.position = s.position + 8'd1;
						end else begin
							s.pin_dir  = 1'b0;
							s.position = s.position - 8'd1;
						end
						s = half_step(s);
						if (s.position == s.recover_target) begin
							s.recovering = 1'b0;
							s.pin_low    = 1'b1;
						end
					end else if (s.ms_since_move > step_thresh) begin
						if (item.limit_active) begin
							s.position = home8;
						end
						s.pin_enable = 1'b1;
						s.pin_low    = 1'b0;
						if (s.position > s.setpoint) begin
							s.pin_dir  = 1'b0;
							s.position = s.position - 8'd1;
						end else begin
							s.pin_dir  = 1'b1;
							s.position = s.position + 8'd1;
						end
						s = half_step(s);
						if (item.limit_active && (s.pin_dir == cfg.homing_direction)) begin
							s.position   = home8;
							s.pin_enable = 1'b0;
						end else if (s.position == home8) begin
							s.homing   = 1'b1;
							s.setpoint = home8;
							s.position = HOMING_START;
						end
						if (s.position == s.setpoint) begin
							s.pin_low = 1'b1;
						end
					end
				end
			end
		end
	end

	assign nxt                = s;
	assign res.step_pin       = s.pin_step;
	assign res.dir_pin        = s.pin_dir;
	assign res.enable_on      = s.pin_enable;
	assign res.low_current    = s.pin_low;
	assign res.position_now   = s.position;
	assign res.at_setpoint    = (s.position == s.setpoint);
	assign res.in_place_event = evt;

endmodule

/* design/stepper_axis_position_controller.sv */
// ----------------------------------------------------------------------------
// stepper_axis_position_controller
// One half-step stepper axis: commands set the setpoint or request homing,
// millisecond ticks move the axis and drive the driver pins.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Carries
//  -------   ------------------   ------------------------------------------
//  in        in_valid/in_ready    func, home_request, target_position,
//                                 step_time_tenths, limit_active
//  out       out_valid/out_ready  step_pin, dir_pin, enable_on, low_current,
//                                 position_now, at_setpoint, in_place_event
//  cfg       cfg_we               cfg_index, cfg_data (write only)
//
// The block takes one word per cycle while the result register is free or
// being taken. A word waits in the input register and its result is loaded
// into the result register at the edge at which the word advances.
// The axis state is updated in the same edge that loads the result, so a
// word always sees the state left by the word before it.
// When the result register is full and not taken, the input register holds
// and in_ready drops; the held word moves on as soon as out_ready rises.
// Reset clears the axis state (step pin high, all other pins low, in-place
// flag set) and loads the configuration reset values.
//
module stepper_axis_position_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input channel.
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic                              home_request,
	input  logic [7:0]                        target_position,
	input  logic [7:0]                        step_time_tenths,
	input  logic                              limit_active,
	// Result channel.
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              step_pin,
	output logic                              dir_pin,
	output logic                              enable_on,
	output logic                              low_current,
	output logic [7:0]                        position_now,
	output logic                              at_setpoint,
	output logic                              in_place_event,
	// Configuration port.
	input  logic                              cfg_we,
	input  logic [spc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [spc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import spc_pkg::*;

	spc_cfg_t    cfg_q;
	spc_item_t   item_s1;
	logic        valid_s1;
	spc_state_t  state_q;
	spc_state_t  state_nxt;
	spc_result_t res_nxt;
	spc_result_t res_q;
	logic        out_valid_q;
	logic        advance;

	// The input register moves forward whenever the result register is free
	// or is being emptied in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Configuration registers. Writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_opening      <= MIN_OPENING_RST;
			cfg_q.max_opening      <= MAX_OPENING_RST;
			cfg_q.home_position    <= HOME_POSITION_RST;
			cfg_q.homing_direction <= 1'b0;
			cfg_q.step_period_ms   <= STEP_PERIOD_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_OPENING:      cfg_q.min_opening      <= cfg_data[6:0];
				CFG_MAX_OPENING:      cfg_q.max_opening      <= cfg_data[6:0];
				CFG_HOME_POSITION:    cfg_q.home_position    <= cfg_data[6:0];
				CFG_HOMING_DIRECTION: cfg_q.homing_direction <= cfg_data[0];
				CFG_STEP_PERIOD_MS:   cfg_q.step_period_ms   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.func             <= func;
			item_s1.home_request     <= home_request;
			item_s1.target_position  <= target_position;
			item_s1.step_time_tenths <= step_time_tenths;
			item_s1.limit_active     <= limit_active;
		end
	end

	spc_next_state u_next (
		.cfg  (cfg_q),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Axis state and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				position:       8'd0,
				setpoint:       8'd0,
				step_time:      8'd0,
				homing:         1'b0,
				recovering:     1'b0,
				recover_target: 8'd0,
				mid_step:       1'b0,
				ms_since_move:  '0,
				all_in_place:   1'b1,
				pin_step:       1'b1,
				pin_dir:        1'b0,
				pin_enable:     1'b0,
				pin_low:        1'b0
			};
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign step_pin       = res_q.step_pin;
	assign dir_pin        = res_q.dir_pin;
	assign enable_on      = res_q.enable_on;
	assign low_current    = res_q.low_current;
	assign position_now   = res_q.position_now;
	assign at_setpoint    = res_q.at_setpoint;
	assign in_place_event = res_q.in_place_event;

	// The shown result always matches the state it was computed with.
	a_setpoint_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (at_setpoint == (position_now == state_q.setpoint)))
		else $error("at_setpoint disagrees with stored setpoint");

	// An in-place event is only reported when the axis is at its setpoint.
	a_event_in_place: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && in_place_event |-> at_setpoint)
		else $error("in-place event without reaching setpoint");

	// Every step pin toggle restarts the millisecond count.
	a_toggle_clears_time: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.pin_step != $past(state_q.pin_step)) |-> (state_q.ms_since_move == '0))
		else $error("step pin toggled without clearing the move timer");

	// A word held in the input register is never dropped while stalled.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input register lost a word during a stall");

endmodule
